// ===== sv/cci_pkg.sv =====
// package: shared widths, codes and defaults for the cell id codec
`timescale 1ns / 1ps
package cci_pkg;

  // field widths
  localparam int GID_W  = 31;
  localparam int BLK_W  = 6;
  localparam int LAY_W  = 8;
  localparam int TRS_W  = 10;
  localparam int STP_W  = 8;
  localparam int CEL_W  = 10;
  localparam int TRAP_W = 5;
  localparam int REG_W  = 2;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // defaults and limits
  localparam int ID_WIDTH_DEF = 31;
  localparam int MAX_TRAPS    = 16;
  localparam int CELL_MAX     = 1023;
  localparam int DIV_STEPS    = 4;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_t;

  typedef enum logic [REG_W-1:0] {
    REG_BARREL    = 2'd0,
    REG_ENDCAP_PZ = 2'd1,
    REG_ENDCAP_NZ = 2'd2
  } region_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRAP_COUNT     = 3'd0,
    CFG_EM_CELLS       = 3'd1,
    CFG_EM_STRIPS      = 3'd2,
    CFG_EM_TRAP_STRIPS = 3'd3,
    CFG_EM_LAYERS      = 3'd4,
    CFG_HD_STRIPS      = 3'd5,
    CFG_HD_TRAP_STRIPS = 3'd6,
    CFG_HD_LAYERS      = 3'd7
  } cfg_idx_t;

endpackage

// ===== sv/cci_in_if.sv =====
// interface: input transaction channel of the cell id codec
`timescale 1ns / 1ps
interface cci_in_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic                        em_section;
  logic [cci_pkg::BLK_W-1:0]   block_in;
  logic [cci_pkg::LAY_W-1:0]   layer_in;
  logic [cci_pkg::TRS_W-1:0]   trap_strip_in;
  logic [cci_pkg::STP_W-1:0]   strip_in;
  logic [cci_pkg::CEL_W-1:0]   cell_in;
  logic [cci_pkg::GID_W-1:0]   global_id_in;

  modport source (output valid, opcode, em_section, block_in, layer_in, trap_strip_in,
                  strip_in, cell_in, global_id_in, input ready);
  modport sink (input valid, opcode, em_section, block_in, layer_in, trap_strip_in,
                strip_in, cell_in, global_id_in, output ready);
endinterface

// ===== sv/cci_out_if.sv =====
// interface: result transaction channel of the cell id codec
`timescale 1ns / 1ps
interface cci_out_if;
  logic                        valid;
  logic                        ready;
  logic [cci_pkg::GID_W-1:0]   global_id_out;
  logic [cci_pkg::BLK_W-1:0]   block_out;
  logic [cci_pkg::LAY_W-1:0]   layer_out;
  logic [cci_pkg::TRS_W-1:0]   trap_strip_out;
  logic [cci_pkg::STP_W-1:0]   strip_out;
  logic [cci_pkg::CEL_W-1:0]   cell_out;
  logic [cci_pkg::REG_W-1:0]   region;
  logic                        is_boundary;
  logic                        is_x_negative;
  logic                        range_error;

  modport source (output valid, global_id_out, block_out, layer_out, trap_strip_out,
                  strip_out, cell_out, region, is_boundary, is_x_negative, range_error,
                  input ready);
  modport sink (input valid, global_id_out, block_out, layer_out, trap_strip_out,
                strip_out, cell_out, region, is_boundary, is_x_negative, range_error,
                output ready);
endinterface

// ===== sv/cci_div_pipe.sv =====
// pipelined restoring divider, STEPS quotient bits per stage, with sideband
`timescale 1ns / 1ps
module cci_div_pipe #(
  parameter int NW    = 31,
  parameter int DW    = 8,
  parameter int SW    = 1,
  parameter int STEPS = cci_pkg::DIV_STEPS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_dvd,
  input  logic [DW-1:0] in_dvs,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] out_quot,
  output logic [DW-1:0] out_rem,
  output logic [SW-1:0] out_side
);

  localparam int NSTG = (NW + STEPS - 1) / STEPS;

  logic          vld_r  [NSTG];
  logic [DW-1:0] rem_r  [NSTG];
  logic [NW-1:0] dq_r   [NSTG];
  logic [DW-1:0] dvs_r  [NSTG];
  logic [SW-1:0] side_r [NSTG];

  // a group of shift-subtract steps; dq holds dividend bits, then quotient bits
  function automatic logic [DW+NW-1:0] div_steps(input logic [DW-1:0] rem,
                                                 input logic [NW-1:0] dq,
                                                 input logic [DW-1:0] d,
                                                 input int base);
    logic [DW:0]   t;
    logic [DW-1:0] r;
    logic [NW-1:0] q;
    r = rem;
    q = dq;
    for (int j = 0; j < STEPS; j++) begin
      if (base + j < NW) begin
        t = {r, q[NW-1]};
        q = {q[NW-2:0], 1'b0};
        if (t >= {1'b0, d}) begin
          t    = t - {1'b0, d};
          q[0] = 1'b1;
        end
        r = t[DW-1:0];
      end
    end
    return {r, q};
  endfunction

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic          src_vld;
    logic [DW-1:0] src_rem;
    logic [NW-1:0] src_dq;
    logic [DW-1:0] src_dvs;
    logic [SW-1:0] src_side;
    logic [DW+NW-1:0] step_nxt;

    // stage source: ports for the first stage, previous stage otherwise
    if (s == 0) begin : g_first
      assign src_vld  = in_valid;
      assign src_rem  = '0;
      assign src_dq   = in_dvd;
      assign src_dvs  = in_dvs;
      assign src_side = in_side;
    end else begin : g_next
      assign src_vld  = vld_r[s-1];
      assign src_rem  = rem_r[s-1];
      assign src_dq   = dq_r[s-1];
      assign src_dvs  = dvs_r[s-1];
      assign src_side = side_r[s-1];
    end

    assign step_nxt = div_steps(src_rem, src_dq, src_dvs, s * STEPS);

    // valid bit
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= src_vld;
      end
    end

    // payload
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= step_nxt[DW+NW-1:NW];
        dq_r[s]   <= step_nxt[NW-1:0];
        dvs_r[s]  <= src_dvs;
        side_r[s] <= src_side;
      end
    end
  end

  assign out_valid = vld_r[NSTG-1];
  assign out_quot  = dq_r[NSTG-1];
  assign out_rem   = rem_r[NSTG-1];
  assign out_side  = side_r[NSTG-1];

endmodule

// ===== sv/calorimeter_cell_id_codec_unit.sv =====
// top level: calorimeter cell id encode/decode pipeline
`timescale 1ns / 1ps
// Converts between a calorimeter channel's indices (cell, strip, trap strip, layer,
// block) and its packed mixed-radix global id, one transaction per clock while the
// input is ready. Five stages of multiply-add build the encoded id, then four
// divider pipelines of eight stages each (four quotient bits per stage) peel off
// block, layer, trap strip and strip, with one stage for the hadronic offset, one
// to form the result and the output register. A stalled output is absorbed by a
// one-entry skid buffer; the input stalls only while that buffer is occupied. The
// user must write configuration registers only while no transaction is in flight;
// the block itself does not enforce this. The electromagnetic total used as hadronic
// offset settles through registers e1_r, e2_r and off_r after a write.
module calorimeter_cell_id_codec_unit #(
  parameter int ID_WIDTH = cci_pkg::ID_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  cci_in_if.sink                          in_ch,
  cci_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [cci_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [cci_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam logic [63:0] ID_LIMIT = (64'd1 << ID_WIDTH) - 64'd1;
  localparam int ACC_W = 43;
  localparam int OFF_W = 36;

  typedef struct packed {
    cci_pkg::op_t                opcode;
    logic                        em;
    logic [cci_pkg::BLK_W-1:0]   blk;
    logic [cci_pkg::LAY_W-1:0]   lay;
    logic [cci_pkg::TRS_W-1:0]   trs;
    logic [cci_pkg::STP_W-1:0]   stp;
    logic [cci_pkg::CEL_W-1:0]   cel;
    logic [cci_pkg::GID_W-1:0]   gid;
    logic [cci_pkg::STP_W-1:0]   ns;
    logic [cci_pkg::TRS_W-1:0]   nt;
    logic [cci_pkg::LAY_W-1:0]   nl;
    logic [cci_pkg::BLK_W-1:0]   nb;
    logic [ACC_W-1:0]            acc;
  } front_t;

  typedef struct packed {
    cci_pkg::op_t                opcode;
    logic                        em;
    logic [cci_pkg::STP_W-1:0]   ns;
    logic [cci_pkg::TRS_W-1:0]   nt;
    logic [cci_pkg::LAY_W-1:0]   nl;
    logic [cci_pkg::GID_W-1:0]   gid;
    logic [cci_pkg::GID_W-1:0]   enc_id;
    logic                        enc_err;
    logic                        err;
    logic [cci_pkg::BLK_W-1:0]   blk;
    cci_pkg::region_t            region;
    logic                        neg;
    logic [cci_pkg::LAY_W-1:0]   layer;
    logic [cci_pkg::TRS_W-1:0]   trs;
  } side_t;

  typedef struct packed {
    logic [cci_pkg::GID_W-1:0]   gid;
    logic [cci_pkg::BLK_W-1:0]   blk;
    logic [cci_pkg::LAY_W-1:0]   layer;
    logic [cci_pkg::TRS_W-1:0]   trs;
    logic [cci_pkg::STP_W-1:0]   stp;
    logic [cci_pkg::CEL_W-1:0]   cel;
    cci_pkg::region_t            region;
    logic                        bnd;
    logic                        xneg;
    logic                        err;
  } res_t;

  localparam int SIDE_W = $bits(side_t);

  // configuration registers
  logic [cci_pkg::TRAP_W-1:0] trap_count_r;
  logic [9:0] em_cells_r, em_trap_strips_r, hd_trap_strips_r;
  logic [7:0] em_strips_r, em_layers_r, hd_strips_r, hd_layers_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trap_count_r     <= 5'd12;
      em_cells_r       <= 10'd1;
      em_strips_r      <= 8'd1;
      em_trap_strips_r <= 10'd1;
      em_layers_r      <= 8'd1;
      hd_strips_r      <= 8'd1;
      hd_trap_strips_r <= 10'd1;
      hd_layers_r      <= 8'd1;
    end else if (cfg_we) begin
      unique case (cci_pkg::cfg_idx_t'(cfg_idx))
        cci_pkg::CFG_TRAP_COUNT:     trap_count_r     <= cfg_wdata[4:0];
        cci_pkg::CFG_EM_CELLS:       em_cells_r       <= cfg_wdata;
        cci_pkg::CFG_EM_STRIPS:      em_strips_r      <= cfg_wdata[7:0];
        cci_pkg::CFG_EM_TRAP_STRIPS: em_trap_strips_r <= cfg_wdata;
        cci_pkg::CFG_EM_LAYERS:      em_layers_r      <= cfg_wdata[7:0];
        cci_pkg::CFG_HD_STRIPS:      hd_strips_r      <= cfg_wdata[7:0];
        cci_pkg::CFG_HD_TRAP_STRIPS: hd_trap_strips_r <= cfg_wdata;
        cci_pkg::CFG_HD_LAYERS:      hd_layers_r      <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // effective counts: zero acts as one, traps capped
  function automatic logic [9:0] ge1_10(input logic [9:0] v);
    return (v == '0) ? 10'd1 : v;
  endfunction
  function automatic logic [7:0] ge1_8(input logic [7:0] v);
    return (v == '0) ? 8'd1 : v;
  endfunction

  logic [cci_pkg::TRAP_W-1:0] traps;
  logic [cci_pkg::BLK_W-1:0]  traps2, nblocks;

  always_comb begin
    if (trap_count_r == '0) begin
      traps = 5'd1;
    end else if (trap_count_r > 5'(cci_pkg::MAX_TRAPS)) begin
      traps = 5'(cci_pkg::MAX_TRAPS);
    end else begin
      traps = trap_count_r;
    end
    traps2  = 6'({1'b0, traps} << 1);
    nblocks = 6'(6'(traps) * 6'd3);
  end

  // electromagnetic total, a product chain through registers e1_r, e2_r and off_r
  logic [17:0]      e1_r;
  logic [27:0]      e2_r;
  logic [OFF_W-1:0] off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_r  <= 18'd1;
      e2_r  <= 28'd1;
      off_r <= 36'd1;
    end else begin
      e1_r  <= 18'(ge1_10(em_cells_r)) * 18'(ge1_8(em_strips_r));
      e2_r  <= 28'(e1_r) * 28'(ge1_10(em_trap_strips_r));
      off_r <= 36'(e2_r) * 36'(ge1_8(em_layers_r));
    end
  end

  // pipeline advance and output skid
  logic en;
  logic skv_r, ov_r;
  res_t sk_r, o_r;
  logic fv_r;
  res_t fin_r;

  assign en          = !skv_r;
  assign in_ch.ready = en;

  // front stages: encode multiply-add chain
  front_t f1_r, f2_r, f3_r, f4_r, f5_r;
  front_t f1_nxt, f2_nxt, f3_nxt, f4_nxt, f5_nxt;
  logic   v1_r, v2_r, v3_r, v4_r, v5_r;

  always_comb begin
    f1_nxt.opcode = cci_pkg::op_t'(in_ch.opcode);
    f1_nxt.em     = in_ch.em_section;
    f1_nxt.blk    = in_ch.block_in;
    f1_nxt.lay    = in_ch.layer_in;
    f1_nxt.trs    = in_ch.trap_strip_in;
    f1_nxt.stp    = in_ch.strip_in;
    f1_nxt.cel    = in_ch.cell_in;
    f1_nxt.gid    = in_ch.global_id_in;
    f1_nxt.ns     = in_ch.em_section ? ge1_8(em_strips_r) : ge1_8(hd_strips_r);
    f1_nxt.nt     = in_ch.em_section ? ge1_10(em_trap_strips_r) : ge1_10(hd_trap_strips_r);
    f1_nxt.nl     = in_ch.em_section ? ge1_8(em_layers_r) : ge1_8(hd_layers_r);
    f1_nxt.nb     = nblocks;
    f1_nxt.acc    = ACC_W'(18'(in_ch.cell_in) * 18'(f1_nxt.ns) + 18'(in_ch.strip_in));

    f2_nxt     = f1_r;
    f2_nxt.acc = ACC_W'(28'(f1_r.acc[17:0]) * 28'(f1_r.nt) + 28'(f1_r.trs));

    f3_nxt     = f2_r;
    f3_nxt.acc = ACC_W'(36'(f2_r.acc[27:0]) * 36'(f2_r.nl) + 36'(f2_r.lay));

    f4_nxt     = f3_r;
    f4_nxt.acc = f3_r.acc + (f3_r.em ? '0 : ACC_W'(off_r));

    f5_nxt     = f4_r;
    f5_nxt.acc = ACC_W'(f4_r.acc[36:0]) * ACC_W'(f4_r.nb) + ACC_W'(f4_r.blk);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r <= f1_nxt;
      f2_r <= f2_nxt;
      f3_r <= f3_nxt;
      f4_r <= f4_nxt;
      f5_r <= f5_nxt;
    end
  end

  // encode result and id range check ahead of the block divider
  side_t d1_sin;

  always_comb begin
    d1_sin         = '0;
    d1_sin.opcode  = f5_r.opcode;
    d1_sin.em      = f5_r.em;
    d1_sin.ns      = f5_r.ns;
    d1_sin.nt      = f5_r.nt;
    d1_sin.nl      = f5_r.nl;
    d1_sin.gid     = f5_r.gid;
    d1_sin.enc_id  = cci_pkg::GID_W'(64'(f5_r.acc) & ID_LIMIT);
    d1_sin.enc_err = 64'(f5_r.acc) > ID_LIMIT;
    d1_sin.err     = 64'(f5_r.gid) > ID_LIMIT;
    d1_sin.region  = cci_pkg::REG_BARREL;
  end

  // block divider
  logic                       d1_v;
  logic [cci_pkg::GID_W-1:0]  d1_quot;
  logic [cci_pkg::BLK_W-1:0]  d1_rem;
  logic [SIDE_W-1:0]          d1_sout;

  cci_div_pipe #(
    .NW (cci_pkg::GID_W),
    .DW (cci_pkg::BLK_W),
    .SW (SIDE_W)
  ) u_div_blk (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v5_r),
    .in_dvd    (f5_r.gid),
    .in_dvs    (f5_r.nb),
    .in_side   (d1_sin),
    .out_valid (d1_v),
    .out_quot  (d1_quot),
    .out_rem   (d1_rem),
    .out_side  (d1_sout)
  );

  // region and hadronic offset removal
  side_t                     m_nxt, m_r;
  logic [cci_pkg::GID_W-1:0] m_dvd_nxt, m_dvd_r;
  logic                      mv_r;

  always_comb begin
    m_nxt     = side_t'(d1_sout);
    m_nxt.blk = d1_rem;
    if (d1_rem < 6'(traps)) begin
      m_nxt.region = cci_pkg::REG_BARREL;
    end else if (d1_rem < traps2) begin
      m_nxt.region = cci_pkg::REG_ENDCAP_PZ;
    end else begin
      m_nxt.region = cci_pkg::REG_ENDCAP_NZ;
    end
    // offset applies to the hadronic section only
    m_nxt.neg = !m_nxt.em && (OFF_W'(d1_quot) < off_r);
    m_dvd_nxt = m_nxt.em ? d1_quot : d1_quot - cci_pkg::GID_W'(off_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else if (en) begin
      mv_r <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r     <= m_nxt;
      m_dvd_r <= m_dvd_nxt;
    end
  end

  // layer divider
  logic                       d2_v;
  logic [cci_pkg::GID_W-1:0]  d2_quot;
  logic [cci_pkg::LAY_W-1:0]  d2_rem;
  logic [SIDE_W-1:0]          d2_sout;
  side_t                      d3_sin;

  cci_div_pipe #(
    .NW (cci_pkg::GID_W),
    .DW (cci_pkg::LAY_W),
    .SW (SIDE_W)
  ) u_div_lay (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (mv_r),
    .in_dvd    (m_dvd_r),
    .in_dvs    (m_r.nl),
    .in_side   (m_r),
    .out_valid (d2_v),
    .out_quot  (d2_quot),
    .out_rem   (d2_rem),
    .out_side  (d2_sout)
  );

  always_comb begin
    d3_sin       = side_t'(d2_sout);
    d3_sin.layer = d2_rem;
  end

  // trap strip divider
  logic                       d3_v;
  logic [cci_pkg::GID_W-1:0]  d3_quot;
  logic [cci_pkg::TRS_W-1:0]  d3_rem;
  logic [SIDE_W-1:0]          d3_sout;
  side_t                      d4_sin;

  cci_div_pipe #(
    .NW (cci_pkg::GID_W),
    .DW (cci_pkg::TRS_W),
    .SW (SIDE_W)
  ) u_div_trs (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d2_v),
    .in_dvd    (d2_quot),
    .in_dvs    (d3_sin.nt),
    .in_side   (d3_sin),
    .out_valid (d3_v),
    .out_quot  (d3_quot),
    .out_rem   (d3_rem),
    .out_side  (d3_sout)
  );

  always_comb begin
    d4_sin     = side_t'(d3_sout);
    d4_sin.trs = d3_rem;
  end

  // strip divider, quotient is the cell
  logic                       d4_v;
  logic [cci_pkg::GID_W-1:0]  d4_quot;
  logic [cci_pkg::STP_W-1:0]  d4_rem;
  logic [SIDE_W-1:0]          d4_sout;

  cci_div_pipe #(
    .NW (cci_pkg::GID_W),
    .DW (cci_pkg::STP_W),
    .SW (SIDE_W)
  ) u_div_stp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d3_v),
    .in_dvd    (d3_quot),
    .in_dvs    (d4_sin.ns),
    .in_side   (d4_sin),
    .out_valid (d4_v),
    .out_quot  (d4_quot),
    .out_rem   (d4_rem),
    .out_side  (d4_sout)
  );

  // result assembly
  side_t d4_sd;
  res_t  fin_nxt;

  always_comb begin
    d4_sd   = side_t'(d4_sout);
    fin_nxt = '0;
    if (d4_sd.opcode == cci_pkg::OP_ENCODE) begin
      fin_nxt.gid = d4_sd.enc_id;
      fin_nxt.err = d4_sd.enc_err;
    end else begin
      fin_nxt.gid    = d4_sd.gid;
      fin_nxt.blk    = d4_sd.blk;
      fin_nxt.region = d4_sd.region;
      fin_nxt.err    = d4_sd.err | d4_sd.neg;
      if (!d4_sd.neg) begin
        fin_nxt.layer = d4_sd.layer;
        fin_nxt.trs   = d4_sd.trs;
        fin_nxt.stp   = d4_rem;
        fin_nxt.cel   = (d4_quot > cci_pkg::GID_W'(cci_pkg::CELL_MAX)) ?
                        cci_pkg::CEL_W'(cci_pkg::CELL_MAX) : d4_quot[cci_pkg::CEL_W-1:0];
        fin_nxt.bnd   = d4_rem != 8'd1;
        fin_nxt.xneg  = d4_rem == 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (en) begin
      fv_r <= d4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r <= fin_nxt;
    end
  end

  // output register with skid entry
  logic push, o_load;

  assign push   = en && fv_r;
  assign o_load = !ov_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      skv_r <= 1'b0;
    end else if (o_load) begin
      if (skv_r) begin
        ov_r  <= 1'b1;
        skv_r <= 1'b0;
      end else begin
        ov_r <= push;
      end
    end else if (push) begin
      skv_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      o_r <= skv_r ? sk_r : fin_r;
    end else if (push) begin
      sk_r <= fin_r;
    end
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.global_id_out  = o_r.gid;
  assign out_ch.block_out      = o_r.blk;
  assign out_ch.layer_out      = o_r.layer;
  assign out_ch.trap_strip_out = o_r.trs;
  assign out_ch.strip_out      = o_r.stp;
  assign out_ch.cell_out       = o_r.cel;
  assign out_ch.region         = o_r.region;
  assign out_ch.is_boundary    = o_r.bnd;
  assign out_ch.is_x_negative  = o_r.xneg;
  assign out_ch.range_error    = o_r.err;

`ifndef ASSERT_OFF
  // skid entry is only used behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skv_r |-> ov_r) else $error("skid entry held without a pending output");

  // skid entry stays until the output register frees
  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    skv_r && !out_ch.ready |=> skv_r) else $error("skid entry dropped while stalled");

  // x-negative implies a boundary strip at index zero
  a_xneg_bnd: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.is_x_negative |-> out_ch.is_boundary && out_ch.strip_out == '0)
    else $error("x-negative flag without boundary strip zero");

  // region code is one of the three detector regions
  a_region_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.region == cci_pkg::REG_BARREL ||
                      out_ch.region == cci_pkg::REG_ENDCAP_PZ ||
                      out_ch.region == cci_pkg::REG_ENDCAP_NZ))
    else $error("unused region code on output");
`endif

endmodule

// ===== test/tb.sv =====
// testbench: calorimeter cell id encode/decode unit, predictor-checked stream
`timescale 1ns / 1ps
module tb;
  import cci_pkg::*;

  typedef struct packed {
    logic              opcode;
    logic              em;
    logic [BLK_W-1:0]  blk;
    logic [LAY_W-1:0]  lay;
    logic [TRS_W-1:0]  trs;
    logic [STP_W-1:0]  stp;
    logic [CEL_W-1:0]  cel;
    logic [GID_W-1:0]  gid;
  } cell_req_t;

  typedef struct packed {
    logic [GID_W-1:0]  gid;
    logic [BLK_W-1:0]  blk;
    logic [LAY_W-1:0]  lay;
    logic [TRS_W-1:0]  trs;
    logic [STP_W-1:0]  stp;
    logic [CEL_W-1:0]  cel;
    logic [REG_W-1:0]  region;
    logic              bnd;
    logic              xneg;
    logic              err;
  } cell_res_t;

  typedef struct packed {
    logic      typed;
    cell_req_t req;
    cell_res_t res;
  } dir_row_t;

  localparam int NUM_DIR    = 12;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_ITEMS = 185;
  localparam int WATCHDOG   = 3000;
  localparam int DRAIN      = 60;
  localparam longint unsigned ID_LIM = (64'd1 << GID_W) - 1;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cci_in_if  in_ch ();
  cci_out_if out_ch ();

  calorimeter_cell_id_codec_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // shadow copy of the configuration registers
  logic [4:0] sh_traps;
  logic [9:0] sh_em_cells, sh_em_trs, sh_hd_trs;
  logic [7:0] sh_em_stp, sh_em_lay, sh_hd_stp, sh_hd_lay;

  cell_res_t expected_ids[$];
  int        fail_count;
  bit        hold_req;
  bit        burst;
  int        idle_cycles;
  dir_row_t  dir_rows [NUM_DIR];

  function automatic longint unsigned radix(longint unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic longint unsigned traps_eff();
    longint unsigned t;
    t = radix(sh_traps);
    return (t > MAX_TRAPS) ? MAX_TRAPS : t;
  endfunction

  // mixed-radix codec predictor
  function automatic cell_res_t predict_cell(cell_req_t rq);
    cell_res_t r;
    longint unsigned tr, nb, ns, nt, nl, off, id, g, b, q, rem, s, c;
    r = '0;
    tr = traps_eff();
    nb = 3 * tr;
    ns = rq.em ? radix(sh_em_stp) : radix(sh_hd_stp);
    nt = rq.em ? radix(sh_em_trs) : radix(sh_hd_trs);
    nl = rq.em ? radix(sh_em_lay) : radix(sh_hd_lay);
    off = rq.em ? 0 : radix(sh_em_cells) * radix(sh_em_stp) * radix(sh_em_trs) *
          radix(sh_em_lay);
    if (rq.opcode == OP_ENCODE) begin
      id = (off + ((longint'(rq.cel) * ns + rq.stp) * nt + rq.trs) * nl + rq.lay) * nb
           + rq.blk;
      r.err = (id > ID_LIM);
      r.gid = id[GID_W-1:0];
    end else begin
      g = rq.gid;
      b = g % nb;
      q = g / nb;
      r.gid = rq.gid;
      r.blk = b[BLK_W-1:0];
      r.region = (b < tr) ? REG_BARREL : ((b < 2 * tr) ? REG_ENDCAP_PZ : REG_ENDCAP_NZ);
      r.err = (g > ID_LIM);
      if (q < off) begin
        r.err = 1'b1;
      end else begin
        rem = q - off;
        r.lay = LAY_W'(rem % nl);
        rem = rem / nl;
        r.trs = TRS_W'(rem % nt);
        rem = rem / nt;
        s = rem % ns;
        c = rem / ns;
        r.stp = s[STP_W-1:0];
        r.cel = (c > CELL_MAX) ? CEL_W'(CELL_MAX) : c[CEL_W-1:0];
        r.bnd = (s != 1);
        r.xneg = (s == 0);
      end
    end
    return r;
  endfunction

  task automatic cmp_field(string name, longint unsigned e, longint unsigned a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      fail_count++;
    end
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result checker
  always @(posedge clk) begin
    cell_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_ids.size() == 0) begin
        $error("result transaction with no expectation waiting");
        fail_count++;
      end else begin
        e = expected_ids.pop_front();
        cmp_field("global_id_out", e.gid, out_ch.global_id_out);
        cmp_field("block_out", e.blk, out_ch.block_out);
        cmp_field("layer_out", e.lay, out_ch.layer_out);
        cmp_field("trap_strip_out", e.trs, out_ch.trap_strip_out);
        cmp_field("strip_out", e.stp, out_ch.strip_out);
        cmp_field("cell_out", e.cel, out_ch.cell_out);
        cmp_field("region", e.region, out_ch.region);
        cmp_field("is_boundary", e.bnd, out_ch.is_boundary);
        cmp_field("is_x_negative", e.xneg, out_ch.is_x_negative);
        cmp_field("range_error", e.err, out_ch.range_error);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("calorimeter_cell_id_codec_unit: mismatch");
      $finish;
    end
  end

  // result sink with random stalls and one long hold
  initial begin
    int w;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end
      w = burst ? 0 : $urandom_range(0, 18);
      if (w > 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // send one transaction after a random gap, record its expectation on accept
  task automatic send_req(cell_req_t rq, bit typed, cell_res_t typed_res);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.opcode        <= rq.opcode;
    in_ch.em_section    <= rq.em;
    in_ch.block_in      <= rq.blk;
    in_ch.layer_in      <= rq.lay;
    in_ch.trap_strip_in <= rq.trs;
    in_ch.strip_in      <= rq.stp;
    in_ch.cell_in       <= rq.cel;
    in_ch.global_id_in  <= rq.gid;
    in_ch.valid         <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    expected_ids.push_back(typed ? typed_res : predict_cell(rq));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_ids.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_TRAP_COUNT:     sh_traps    = val[4:0];
      CFG_EM_CELLS:       sh_em_cells = val[9:0];
      CFG_EM_STRIPS:      sh_em_stp   = val[7:0];
      CFG_EM_TRAP_STRIPS: sh_em_trs   = val[9:0];
      CFG_EM_LAYERS:      sh_em_lay   = val[7:0];
      CFG_HD_STRIPS:      sh_hd_stp   = val[7:0];
      CFG_HD_TRAP_STRIPS: sh_hd_trs   = val[9:0];
      default:            sh_hd_lay   = val[7:0];
    endcase
    @(posedge clk);
  endtask

  // count: max in ph 1, zero in ph 2, else mostly small, sometimes any value
  function automatic logic [CFG_DATA_W-1:0] pick_count(int ph, int w);
    longint unsigned full;
    full = (64'd1 << w) - 1;
    if (ph == 1) return CFG_DATA_W'(full);
    if (ph == 2) return '0;
    if ($urandom_range(0, 3) == 0) return CFG_DATA_W'($urandom_range(0, full));
    return CFG_DATA_W'($urandom_range(0, 7));
  endfunction

  // random transaction, mostly well formed for the current radices
  function automatic cell_req_t rand_req();
    cell_req_t rq;
    cell_req_t enc;
    longint unsigned nb, ns, nt, nl, off;
    int sel;
    rq = cell_req_t'({$urandom, $urandom, $urandom});
    rq.opcode = 1'($urandom_range(0, 1));
    rq.em = 1'($urandom_range(0, 1));
    nb = 3 * traps_eff();
    ns = rq.em ? radix(sh_em_stp) : radix(sh_hd_stp);
    nt = rq.em ? radix(sh_em_trs) : radix(sh_hd_trs);
    nl = rq.em ? radix(sh_em_lay) : radix(sh_hd_lay);
    sel = $urandom_range(0, 9);
    enc = rq;
    enc.opcode = OP_ENCODE;
    if (sel < 7) begin
      enc.blk = BLK_W'($urandom_range(0, nb - 1));
      enc.lay = LAY_W'($urandom_range(0, nl - 1));
      enc.trs = TRS_W'($urandom_range(0, nt - 1));
      enc.stp = STP_W'($urandom_range(0, ns - 1));
      enc.cel = ($urandom_range(0, 1) == 0) ? CEL_W'($urandom_range(0, 3)) :
                CEL_W'($urandom_range(0, 1023));
    end
    if (rq.opcode == OP_ENCODE) return enc;
    if (sel < 6) begin
      rq.gid = predict_cell(enc).gid;
    end else if (sel < 8) begin
      off = radix(sh_em_cells) * radix(sh_em_stp) * radix(sh_em_trs) * radix(sh_em_lay);
      off = off * nb + nb;
      rq.gid = GID_W'($urandom_range(0, (off > ID_LIM) ? ID_LIM : off));
    end
    return rq;
  endfunction

  // stimulus
  initial begin
    cell_req_t rq;
    cell_res_t none;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_TRAP_COUNT;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_ENCODE;
    in_ch.em_section = 1'b0;
    in_ch.block_in = '0;
    in_ch.layer_in = '0;
    in_ch.trap_strip_in = '0;
    in_ch.strip_in = '0;
    in_ch.cell_in = '0;
    in_ch.global_id_in = '0;
    fail_count = 0;
    hold_req = 1'b0;
    burst = 1'b0;
    idle_cycles = 0;
    none = '0;
    sh_traps = 5'd12;
    sh_em_cells = 10'd1;
    sh_em_trs = 10'd1;
    sh_hd_trs = 10'd1;
    sh_em_stp = 8'd1;
    sh_em_lay = 8'd1;
    sh_hd_stp = 8'd1;
    sh_hd_lay = 8'd1;

    // directed rows under the reset configuration: 36 blocks, unit radices, offset 1
    //            typed  op  em  blk  lay  trs   stp  cel   gid
    dir_rows[0]  = '{1'b1, '{OP_ENCODE, 1'b1, 6'd0, 8'd0, 10'd0, 8'd0, 10'd0, 31'd0},
                     '{31'd0, 6'd0, 8'd0, 10'd0, 8'd0, 10'd0, REG_BARREL, 1'b0, 1'b0, 1'b0}};
    dir_rows[1]  = '{1'b1, '{OP_ENCODE, 1'b1, 6'd63, 8'd255, 10'd1023, 8'd255, 10'd1023, 31'd0},
                     '{31'd92079, 6'd0, 8'd0, 10'd0, 8'd0, 10'd0, REG_BARREL, 1'b0, 1'b0, 1'b0}};
    dir_rows[2]  = '{1'b1, '{OP_ENCODE, 1'b0, 6'd0, 8'd0, 10'd0, 8'd0, 10'd0, 31'd0},
                     '{31'd36, 6'd0, 8'd0, 10'd0, 8'd0, 10'd0, REG_BARREL, 1'b0, 1'b0, 1'b0}};
    dir_rows[3]  = '{1'b1, '{OP_DECODE, 1'b1, 6'd0, 8'd0, 10'd0, 8'd0, 10'd0, 31'd0},
                     '{31'd0, 6'd0, 8'd0, 10'd0, 8'd0, 10'd0, REG_BARREL, 1'b1, 1'b1, 1'b0}};
    // hadronic decode below the EM total
    dir_rows[4]  = '{1'b1, '{OP_DECODE, 1'b0, 6'd0, 8'd0, 10'd0, 8'd0, 10'd0, 31'd0},
                     '{31'd0, 6'd0, 8'd0, 10'd0, 8'd0, 10'd0, REG_BARREL, 1'b0, 1'b0, 1'b1}};
    dir_rows[5]  = '{1'b0, '{OP_DECODE, 1'b1, 6'd0, 8'd0, 10'd0, 8'd0, 10'd0, 31'h7fffffff},
                     none};
    dir_rows[6]  = '{1'b0, '{OP_DECODE, 1'b1, 6'd0, 8'd0, 10'd0, 8'd0, 10'd0, 31'd11}, none};
    dir_rows[7]  = '{1'b0, '{OP_DECODE, 1'b1, 6'd0, 8'd0, 10'd0, 8'd0, 10'd0, 31'd12}, none};
    dir_rows[8]  = '{1'b0, '{OP_DECODE, 1'b1, 6'd0, 8'd0, 10'd0, 8'd0, 10'd0, 31'd35}, none};
    dir_rows[9]  = '{1'b0, '{OP_DECODE, 1'b0, 6'd0, 8'd0, 10'd0, 8'd0, 10'd0, 31'd36}, none};
    dir_rows[10] = '{1'b0, '{OP_ENCODE, 1'b0, 6'h2a, 8'h55, 10'h2aa, 8'haa, 10'h155, 31'd0},
                     none};
    dir_rows[11] = '{1'b0, '{OP_DECODE, 1'b0, 6'h15, 8'haa, 10'h155, 8'h55, 10'h2aa,
                     31'h2aaaaaaa}, none};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_DIR; i++)
      send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
    wait_drained();

    // random phases: max radices, zero radices, oversized trap count, then random
    for (int ph = 1; ph <= NUM_PHASES; ph++) begin
      cfg_write(CFG_TRAP_COUNT, (ph == 1) ? 10'd16 : (ph == 2) ? 10'd0 :
                                (ph == 3) ? 10'd31 : CFG_DATA_W'($urandom_range(0, 31)));
      cfg_write(CFG_EM_CELLS, pick_count(ph, 10));
      cfg_write(CFG_EM_STRIPS, pick_count(ph, 8));
      cfg_write(CFG_EM_TRAP_STRIPS, pick_count(ph, 10));
      cfg_write(CFG_EM_LAYERS, pick_count(ph, 8));
      cfg_write(CFG_HD_STRIPS, pick_count(ph, 8));
      cfg_write(CFG_HD_TRAP_STRIPS, pick_count(ph, 10));
      cfg_write(CFG_HD_LAYERS, pick_count(ph, 8));
      cfg_we <= 1'b0;
      repeat (5) @(posedge clk);
      burst = (ph % 4 == 0);
      if (ph == 5) hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        rq = rand_req();
        send_req(rq, 1'b0, none);
      end
      burst = 1'b0;
      wait_drained();
    end

    if (fail_count == 0 && expected_ids.size() == 0)
      $display("calorimeter_cell_id_codec_unit: match");
    else
      $display("calorimeter_cell_id_codec_unit: mismatch");
    $finish;
  end

endmodule
